/* design/dslcd_pkg.sv */
// Types and constants shared by the dual sensor line cross detector.
`default_nettype none

package dslcd_pkg;

    // Field widths
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned POS_W   = 32;
    localparam int unsigned TICKS_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_TH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_TH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STRIPE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SKEW   = 2'd3;

    // Configuration reset values
    localparam logic [LEVEL_W-1:0] BLACK_TH_RST   = 8'd128;
    localparam logic [LEVEL_W-1:0] WHITE_TH_RST   = 8'd64;
    localparam logic [TICKS_W-1:0] MAX_STRIPE_RST = 16'd700;
    localparam logic [TICKS_W-1:0] MAX_SKEW_RST   = 16'd1500;

    // Per-side tracker state
    typedef struct packed {
        logic             on_white;
        logic [POS_W-1:0] entry_position;
        logic             marked;
        logic [POS_W-1:0] cross_position;
    } side_state_t;

    // Thresholds the trackers share
    typedef struct packed {
        logic [LEVEL_W-1:0] black_th;
        logic [LEVEL_W-1:0] white_th;
        logic [TICKS_W-1:0] max_stripe;
    } side_cfg_t;

endpackage

`default_nettype wire

/* design/dslcd_if.sv */
// Valid/ready channels for sensor samples and detector results.
`default_nettype none

interface dslcd_sample_if
    import dslcd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic        [LEVEL_W-1:0] left_level;
    logic        [LEVEL_W-1:0] right_level;
    logic signed [POS_W-1:0]   encoder_position;

    modport source (output valid, left_level, right_level, encoder_position, input ready);
    modport sink   (input valid, left_level, right_level, encoder_position, output ready);
endinterface

interface dslcd_result_if
    import dslcd_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] line_count;
    logic               line_found;
    logic               left_crossing;
    logic               right_crossing;

    modport source (output valid, line_count, line_found, left_crossing, right_crossing,
                    input ready);
    modport sink   (input valid, line_count, line_found, left_crossing, right_crossing,
                    output ready);
endinterface

`default_nettype wire

/* design/dslcd_side.sv */
// One sensor's black/white tracker with hysteresis and stripe qualification.
`default_nettype none

module dslcd_side
    import dslcd_pkg::*;
(
    input  wire side_cfg_t          cfg,
    input  wire side_state_t        cur,
    input  wire logic [LEVEL_W-1:0] level,
    input  wire logic [POS_W-1:0]   pos,
    output side_state_t             nxt,
    output logic                    crossed
);

    logic             enter;
    logic             on_white_mid;
    logic [POS_W-1:0] entry_mid;
    logic             marked_mid;
    logic             leave;
    logic [POS_W-1:0] travel;
    logic             short_travel;

    // Enter white: record entry position, drop the mark
    always_comb
    begin
        enter        = !cur.on_white && (level <= cfg.white_th);
        on_white_mid = cur.on_white || enter;
        entry_mid    = enter ? pos : cur.entry_position;
        marked_mid   = enter ? 1'b0 : cur.marked;
    end

    // Return to black: signed wrapped travel must be under the stripe limit
    always_comb
    begin
        leave        = on_white_mid && (level > cfg.black_th);
        travel       = pos - entry_mid;
        short_travel = travel[POS_W-1] ||
                       (travel < {{(POS_W-TICKS_W){1'b0}}, cfg.max_stripe});
        crossed      = leave && short_travel;

        nxt.on_white       = on_white_mid && !leave;
        nxt.entry_position = entry_mid;
        nxt.marked         = crossed ? 1'b1 : marked_mid;
        nxt.cross_position = crossed ? pos : cur.cross_position;
    end

endmodule

`default_nettype wire

/* design/dual_sensor_line_cross_detector_unit.sv */
// Dual sensor line cross detector: top level with config, pipeline and pairing.
//
// Usage:
//   sample channel: one word per sensor sample (left level, right level,
//   encoder position). result channel: one word per sample with the running
//   line count, a line-found flag and the per-side crossing flags.
//   Config port: wr_en/wr_index/wr_data write the thresholds and limits; write
//   only while no sample is in flight.
// Timing:
//   A taken sample is registered in the input stage, evaluated by the side
//   trackers and pair check, and its result word is registered as the input
//   stage advances. One sample per cycle is sustained while result.ready is
//   high; the tracker state update is a single registered pass per sample.
// Reset:
//   rst_n clears the trackers, the line counter and the valid flags of both
//   pipeline stages, and loads the default thresholds and limits.
// Stall:
//   With the result stage held by a low result.ready, one more sample is
//   taken into the input stage; sample.ready then drops until the result
//   word moves.
`default_nettype none

module dual_sensor_line_cross_detector_unit
    import dslcd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    dslcd_sample_if.sink               sample,
    dslcd_result_if.source             result
);

    // Configuration registers
    logic [LEVEL_W-1:0] black_th_reg;
    logic [LEVEL_W-1:0] white_th_reg;
    logic [TICKS_W-1:0] max_stripe_reg;
    logic [TICKS_W-1:0] max_skew_reg;

    // Input stage
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] left_level_reg;
    logic [LEVEL_W-1:0] right_level_reg;
    logic [POS_W-1:0]   pos_reg;

    // Tracker state
    side_state_t        left_reg;
    side_state_t        right_reg;
    logic [COUNT_W-1:0] count_reg;

    // Result stage
    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_found_reg;
    logic               out_left_reg;
    logic               out_right_reg;

    side_cfg_t          side_cfg;
    side_state_t        left_mid;
    side_state_t        right_mid;
    side_state_t        left_next;
    side_state_t        right_next;
    logic               left_cross;
    logic               right_cross;
    logic               both_marked;
    logic [POS_W:0]     skew_diff;
    logic [POS_W:0]     skew_abs;
    logic               skew_ok;
    logic               found;
    logic [COUNT_W-1:0] count_next;
    logic               advance;
    logic               take;

    // Handshake: the input stage moves when the result stage is free or draining
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_th_reg   <= BLACK_TH_RST;
            white_th_reg   <= WHITE_TH_RST;
            max_stripe_reg <= MAX_STRIPE_RST;
            max_skew_reg   <= MAX_SKEW_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BLACK_TH:   black_th_reg   <= wr_data[LEVEL_W-1:0];
                REG_WHITE_TH:   white_th_reg   <= wr_data[LEVEL_W-1:0];
                REG_MAX_STRIPE: max_stripe_reg <= wr_data[TICKS_W-1:0];
                REG_MAX_SKEW:   max_skew_reg   <= wr_data[TICKS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            left_level_reg  <= sample.left_level;
            right_level_reg <= sample.right_level;
            pos_reg         <= sample.encoder_position;
        end
    end

    // Side trackers, left then right
    assign side_cfg.black_th   = black_th_reg;
    assign side_cfg.white_th   = white_th_reg;
    assign side_cfg.max_stripe = max_stripe_reg;

    dslcd_side u_left (
        .cfg     (side_cfg),
        .cur     (left_reg),
        .level   (left_level_reg),
        .pos     (pos_reg),
        .nxt     (left_mid),
        .crossed (left_cross)
    );

    dslcd_side u_right (
        .cfg     (side_cfg),
        .cur     (right_reg),
        .level   (right_level_reg),
        .pos     (pos_reg),
        .nxt     (right_mid),
        .crossed (right_cross)
    );

    // Pair check: exact 33-bit skew, then both marks resolve either way
    always_comb
    begin
        both_marked = left_mid.marked && right_mid.marked;
        skew_diff   = {right_mid.cross_position[POS_W-1], right_mid.cross_position} -
                      {left_mid.cross_position[POS_W-1], left_mid.cross_position};
        skew_abs    = skew_diff[POS_W] ? (~skew_diff + 1'b1) : skew_diff;
        skew_ok     = skew_abs < {{(POS_W+1-TICKS_W){1'b0}}, max_skew_reg};
        found       = both_marked && skew_ok;
        count_next  = found ? (count_reg + 1'b1) : count_reg;

        left_next  = left_mid;
        right_next = right_mid;
        if (both_marked)
        begin
            left_next.marked          = 1'b0;
            right_next.marked         = 1'b0;
            left_next.cross_position  = '0;
            right_next.cross_position = '0;
        end
    end

    // Tracker state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            count_reg <= '0;
        end
        else if (advance)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            count_reg <= count_next;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_count_reg <= count_next;
            out_found_reg <= found;
            out_left_reg  <= left_cross;
            out_right_reg <= right_cross;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.line_count     = out_count_reg;
    assign result.line_found     = out_found_reg;
    assign result.left_crossing  = out_left_reg;
    assign result.right_crossing = out_right_reg;

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the dual sensor line cross detector: directed and random samples, checked per word.
`timescale 1ns / 100ps

module tb_top
    import dslcd_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SIDE_L      = 0;
    localparam int SIDE_R      = 1;

    // Expected contents of one result word
    typedef struct packed {
        logic [COUNT_W-1:0] line_count;
        logic               line_found;
        logic               left_crossing;
        logic               right_crossing;
    } line_report_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    dslcd_sample_if sample_ch ();
    dslcd_result_if result_ch ();

    dual_sensor_line_cross_detector_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample_ch),
        .result   (result_ch)
    );

    // Predictor state: trackers, thresholds, running line total
    side_state_t        side_trk [2];
    side_cfg_t          trk_cfg;
    logic [TICKS_W-1:0] skew_limit;
    logic [COUNT_W-1:0] line_total;

    line_report_t line_reports_due [$];

    int send_idle_pct;
    int recv_stall_pct;
    int samples_sent;
    int mismatch_count;
    int cycle_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** dual_sensor_line_cross_detector_unit: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin : check_words
        line_report_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (line_reports_due.size() == 0)
            begin
                report_mismatch($sformatf("word with nothing expected, count %0d",
                                          result_ch.line_count));
            end
            else
            begin
                want = line_reports_due.pop_front();
                if (result_ch.line_count !== want.line_count)
                    report_mismatch($sformatf("line_count %0d, want %0d",
                                              result_ch.line_count, want.line_count));
                if (result_ch.line_found !== want.line_found)
                    report_mismatch($sformatf("line_found %b, want %b",
                                              result_ch.line_found, want.line_found));
                if (result_ch.left_crossing !== want.left_crossing)
                    report_mismatch($sformatf("left_crossing %b, want %b",
                                              result_ch.left_crossing, want.left_crossing));
                if (result_ch.right_crossing !== want.right_crossing)
                    report_mismatch($sformatf("right_crossing %b, want %b",
                                              result_ch.right_crossing, want.right_crossing));
            end
        end
    end

    task automatic clear_predictor();
        int s;
        for (s = 0; s < 2; s++)
            side_trk[s] = '0;
        trk_cfg.black_th   = BLACK_TH_RST;
        trk_cfg.white_th   = WHITE_TH_RST;
        trk_cfg.max_stripe = MAX_STRIPE_RST;
        skew_limit         = MAX_SKEW_RST;
        line_total         = '0;
    endtask

    // One side: enter white first, then the return to black
    task automatic advance_tracker(input int s, input logic [LEVEL_W-1:0] lvl,
                                   input logic [POS_W-1:0] pos, output logic crossed);
        logic signed [POS_W-1:0] travel;
        crossed = 1'b0;
        if (!side_trk[s].on_white && lvl <= trk_cfg.white_th)
        begin
            side_trk[s].on_white       = 1'b1;
            side_trk[s].marked         = 1'b0;
            side_trk[s].entry_position = pos;
        end
        if (side_trk[s].on_white && lvl > trk_cfg.black_th)
        begin
            side_trk[s].on_white = 1'b0;
            // wrapped travel, read as signed
            travel = pos - side_trk[s].entry_position;
            if (travel < $signed({16'd0, trk_cfg.max_stripe}))
            begin
                side_trk[s].marked         = 1'b1;
                side_trk[s].cross_position = pos;
                crossed                    = 1'b1;
            end
        end
    endtask

    task automatic predict_line_report(input logic [LEVEL_W-1:0] lvl_l,
                                       input logic [LEVEL_W-1:0] lvl_r,
                                       input logic [POS_W-1:0] pos);
        line_report_t rep;
        logic         cross_l;
        logic         cross_r;
        longint       skew;
        advance_tracker(SIDE_L, lvl_l, pos, cross_l);
        advance_tracker(SIDE_R, lvl_r, pos, cross_r);
        rep.line_found = 1'b0;
        // pair resolved: exact skew, marks cleared either way
        if (side_trk[SIDE_L].marked && side_trk[SIDE_R].marked)
        begin
            skew = longint'($signed(side_trk[SIDE_R].cross_position))
                 - longint'($signed(side_trk[SIDE_L].cross_position));
            if (skew < 0)
                skew = -skew;
            if (skew < longint'(skew_limit))
            begin
                line_total     = line_total + 1'b1;
                rep.line_found = 1'b1;
            end
            side_trk[SIDE_L].marked         = 1'b0;
            side_trk[SIDE_R].marked         = 1'b0;
            side_trk[SIDE_L].cross_position = '0;
            side_trk[SIDE_R].cross_position = '0;
        end
        rep.line_count     = line_total;
        rep.left_crossing  = cross_l;
        rep.right_crossing = cross_r;
        line_reports_due.push_back(rep);
    endtask

    // Send one sample word, with random idle cycles ahead of it
    task automatic send_sample(input logic [LEVEL_W-1:0] lvl_l, input logic [LEVEL_W-1:0] lvl_r,
                               input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid            <= 1'b1;
        sample_ch.left_level       <= lvl_l;
        sample_ch.right_level      <= lvl_r;
        sample_ch.encoder_position <= pos;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        predict_line_report(lvl_l, lvl_r, pos);
        samples_sent++;
    endtask

    // Stop sending and wait for every expected word
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (line_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_BLACK_TH:   trk_cfg.black_th   = data[LEVEL_W-1:0];
            REG_WHITE_TH:   trk_cfg.white_th   = data[LEVEL_W-1:0];
            REG_MAX_STRIPE: trk_cfg.max_stripe = data;
            REG_MAX_SKEW:   skew_limit         = data;
            default: ;
        endcase
    endtask

    // All four registers, only once the block is idle
    task automatic load_limits(input logic [LEVEL_W-1:0] black, input logic [LEVEL_W-1:0] white,
                               input logic [TICKS_W-1:0] stripe, input logic [TICKS_W-1:0] skew);
        wait_drained();
        write_reg(REG_BLACK_TH, {8'd0, black});
        write_reg(REG_WHITE_TH, {8'd0, white});
        write_reg(REG_MAX_STRIPE, stripe);
        write_reg(REG_MAX_SKEW, skew);
        wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // Level for one side under the current thresholds
    function automatic logic [LEVEL_W-1:0] pick_level(input bit on_stripe);
        int lo;
        if (on_stripe)
            return LEVEL_W'($urandom_range(0, int'(trk_cfg.white_th)));
        // sometimes a level inside the hysteresis band
        if (trk_cfg.white_th < trk_cfg.black_th && $urandom_range(7) == 0)
            return LEVEL_W'($urandom_range(int'(trk_cfg.white_th) + 1, int'(trk_cfg.black_th)));
        lo = (trk_cfg.black_th == 8'd255) ? 255 : int'(trk_cfg.black_th) + 1;
        return LEVEL_W'($urandom_range(lo, 255));
    endfunction

    // One pass over a stripe; a zero width leaves that side on black
    task automatic send_line_pass();
        int                n;
        int                le;
        int                lw;
        int                re;
        int                rw;
        int                k;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  stride;
        n      = $urandom_range(3, 10);
        le     = $urandom_range(0, 2);
        lw     = $urandom_range(0, 4);
        re     = $urandom_range(0, 2);
        rw     = $urandom_range(0, 4);
        pos    = $urandom;
        stride = $urandom_range(0, (int'(trk_cfg.max_stripe) >> 1) + 16);
        if ($urandom_range(9) == 0)
            stride = -stride;
        for (k = 0; k < n; k++)
        begin
            send_sample(pick_level(k >= le && k < le + lw), pick_level(k >= re && k < re + rw), pos);
            pos = pos + stride;
        end
    endtask

    // Mostly stripe passes, some raw noise words
    task automatic run_traffic(input int count);
        int stop_at;
        int k;
        stop_at = samples_sent + count;
        while (samples_sent < stop_at)
        begin
            if ($urandom_range(9) < 8)
                send_line_pass();
            else
                for (k = $urandom_range(1, 3); k > 0; k--)
                    send_sample(LEVEL_W'($urandom), LEVEL_W'($urandom), $urandom);
        end
    endtask

    // Directed cases

    task automatic test_black_and_extremes();
        send_sample(8'd255, 8'd255, 32'h0000_0000);
        send_sample(8'd200, 8'd129, 32'h7FFF_FFFF);
        send_sample(8'd129, 8'd200, 32'h8000_0000);
    endtask

    task automatic test_narrow_line();
        send_sample(8'd0, 8'd0, 32'd100);
        send_sample(8'd255, 8'd255, 32'd699);
    endtask

    task automatic test_threshold_edges();
        // level equal to white threshold enters, travel equal to limit fails
        send_sample(8'd64, 8'd64, 32'd1000);
        send_sample(8'd129, 8'd129, 32'd1700);
        // level equal to black threshold stays on white
        send_sample(8'd0, 8'd0, 32'd2000);
        send_sample(8'd128, 8'd128, 32'd2100);
        send_sample(8'd255, 8'd255, 32'd2200);
    endtask

    task automatic test_backward_travel();
        send_sample(8'd10, 8'd10, 32'd5000);
        send_sample(8'd250, 8'd250, 32'd2000);
    endtask

    task automatic test_wrap_and_wide_skew();
        // right travel crosses the sign boundary; skew is near 2^32, not 1
        send_sample(8'd0, 8'd0, 32'h7FFF_FF80);
        send_sample(8'd255, 8'd0, 32'h7FFF_FFFF);
        send_sample(8'd255, 8'd255, 32'h8000_0000);
    endtask

    task automatic test_skew_limit();
        logic [POS_W-1:0] base;
        base = -32'sd50000;
        send_sample(8'd0, 8'd0, base);
        send_sample(8'd255, 8'd0, base + 32'd10);
        send_sample(8'd255, 8'd255, base + 32'd1509);
        send_sample(8'd0, 8'd0, base + 32'd3000);
        send_sample(8'd255, 8'd0, base + 32'd3010);
        send_sample(8'd255, 8'd255, base + 32'd4510);
    endtask

    task automatic test_mark_cleared();
        send_sample(8'd0, 8'd0, 32'd100);
        send_sample(8'd255, 8'd0, 32'd150);
        // left re-enters white and drops its mark
        send_sample(8'd0, 8'd0, 32'd160);
        send_sample(8'd0, 8'd255, 32'd200);
        send_sample(8'd255, 8'd255, 32'd210);
    endtask

    task automatic test_overlap_thresholds();
        load_limits(8'd100, 8'd200, MAX_STRIPE_RST, MAX_SKEW_RST);
        send_sample(8'd150, 8'd150, 32'd12345);
        // zero travel is not below a zero limit
        load_limits(8'd100, 8'd200, 16'd0, MAX_SKEW_RST);
        send_sample(8'd150, 8'd150, 32'd12345);
    endtask

    task automatic test_count_wrap();
        int n;
        int k;
        load_limits(8'd100, 8'd200, MAX_STRIPE_RST, MAX_SKEW_RST);
        n = 256 - int'(line_total) + 4;
        for (k = 0; k < n; k++)
            send_sample(LEVEL_W'($urandom_range(101, 200)), LEVEL_W'($urandom_range(101, 200)),
                        $urandom);
    endtask

    task automatic test_random_defaults();
        load_limits(BLACK_TH_RST, WHITE_TH_RST, MAX_STRIPE_RST, MAX_SKEW_RST);
        run_traffic(350);
    endtask

    task automatic test_random_limits();
        load_limits(LEVEL_W'($urandom), LEVEL_W'($urandom),
                    TICKS_W'($urandom_range(0, 4000)), TICKS_W'($urandom_range(0, 4000)));
        run_traffic(175);
        // hold off until every word is back, then a new setting
        load_limits(LEVEL_W'($urandom), LEVEL_W'($urandom),
                    TICKS_W'($urandom_range(0, 4000)), TICKS_W'($urandom_range(0, 4000)));
        run_traffic(175);
    endtask

    task automatic test_extreme_limits();
        load_limits(8'd0, 8'd255, 16'hFFFF, 16'hFFFF);
        run_traffic(200);
        load_limits(8'd255, 8'd0, 16'hFFFF, 16'd0);
        run_traffic(100);
        load_limits(8'd0, 8'd0, 16'd0, 16'd1);
        run_traffic(150);
    endtask

    // Test sequence
    initial
    begin
        rst_n                      <= 1'b0;
        wr_en                      <= 1'b0;
        wr_index                   <= REG_BLACK_TH;
        wr_data                    <= '0;
        sample_ch.valid            <= 1'b0;
        sample_ch.left_level       <= '0;
        sample_ch.right_level      <= '0;
        sample_ch.encoder_position <= '0;
        samples_sent   = 0;
        clear_predictor();
        set_idling(16, 62);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_black_and_extremes();
        test_narrow_line();
        test_threshold_edges();
        test_backward_travel();
        test_wrap_and_wide_skew();
        test_skew_limit();
        test_mark_cleared();
        test_overlap_thresholds();
        test_count_wrap();
        test_random_defaults();

        wait_drained();
        set_idling(62, 16);
        test_random_limits();

        wait_drained();
        set_idling(0, 0);
        test_extreme_limits();

        wait_drained();
        if (mismatch_count == 0)
            $display("** dual_sensor_line_cross_detector_unit: PASSED **");
        else
            $display("** dual_sensor_line_cross_detector_unit: FAILED **");
        $finish;
    end

endmodule

/* dual_sensor_line_cross_detector_unit.f */
design/dslcd_pkg.sv
design/dslcd_if.sv
design/dslcd_side.sv
design/dual_sensor_line_cross_detector_unit.sv
test/tb_top.sv
